### src/bfp_pkg.sv
// Shared types, constants and helpers for the byte ring FIFO with peek cursor.
package bfp_pkg;

  localparam int unsigned DEPTH = 64;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned BYTE_W = 8;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [PTR_W-1:0] ptr_t;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_PEEK   = 2'd2,
    OP_REWIND = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_NOSRC = 2'd3
  } status_t;

  // One cycle's worth of storage traffic from the controller.
  typedef struct packed {
    logic  wr_en;
    ptr_t  wr_addr;
    byte_t wr_data;
    logic  rd_en;
    ptr_t  rd_addr;
  } mem_req_t;

  localparam ptr_t PTR_LAST = ptr_t'(DEPTH - 1);

  function automatic ptr_t ptr_inc(input ptr_t p);
    ptr_t r;
    if (p == PTR_LAST) begin
      r = '0;
    end else begin
      r = p + ptr_t'(1);
    end
    return r;
  endfunction

endpackage

### src/bfp_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module bfp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned WORDS = 64
) (
  input  logic                                       clk,
  input  logic                                       wr_en,
  input  logic [((WORDS > 1) ? $clog2(WORDS) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                           wr_data,
  input  logic                                       rd_en,
  input  logic [((WORDS > 1) ? $clog2(WORDS) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                           rd_data
);

  logic [WIDTH-1:0] mem [WORDS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### src/bfp_ctrl.sv
// Pointer registers, request decode and result registers of the ring FIFO.
module bfp_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  bfp_pkg::op_t       opcode,
  input  bfp_pkg::byte_t     data_byte,
  input  logic               source_valid,
  output bfp_pkg::mem_req_t  mem_req,
  input  bfp_pkg::byte_t     rd_data,
  output logic               result_valid,
  output bfp_pkg::byte_t     read_byte,
  output bfp_pkg::status_t   status
);

  import bfp_pkg::*;

  ptr_t    head;
  ptr_t    tail;
  ptr_t    cursor;
  ptr_t    head_next;
  ptr_t    tail_next;
  ptr_t    cursor_next;
  status_t status_next;
  byte_t   byte_next;
  logic    from_ram_next;
  logic    from_ram;
  byte_t   byte_q;
  logic    full;
  logic    empty;
  logic    at_tail;

  assign full    = (ptr_inc(tail) == head);
  assign empty   = (head == tail);
  assign at_tail = (cursor == tail);

  always_comb begin
    head_next     = head;
    tail_next     = tail;
    cursor_next   = cursor;
    status_next   = ST_OK;
    byte_next     = '0;
    from_ram_next = 1'b0;
    mem_req       = '0;
    mem_req.wr_addr = tail;
    mem_req.wr_data = data_byte;
    mem_req.rd_addr = head;
    case (opcode)
      OP_PUSH: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          mem_req.wr_en = accept;
          tail_next     = ptr_inc(tail);
        end
      end
      OP_POP: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          mem_req.rd_en = accept;
          from_ram_next = 1'b1;
          head_next     = ptr_inc(head);
        end
      end
      OP_PEEK: begin
        if (at_tail) begin
          if (!source_valid) begin
            status_next = ST_NOSRC;
          end else if (full) begin
            status_next = ST_FULL;
          end else begin
            // The refill byte lands at the cursor, so it is answered directly.
            mem_req.wr_en = accept;
            tail_next     = ptr_inc(tail);
            cursor_next   = ptr_inc(cursor);
            byte_next     = data_byte;
          end
        end else begin
          mem_req.rd_en   = accept;
          mem_req.rd_addr = cursor;
          from_ram_next   = 1'b1;
          cursor_next     = ptr_inc(cursor);
        end
      end
      OP_REWIND: begin
        cursor_next = head;
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head         <= '0;
      tail         <= '0;
      cursor       <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= accept;
      if (accept) begin
        head   <= head_next;
        tail   <= tail_next;
        cursor <= cursor_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status   <= status_next;
      byte_q   <= byte_next;
      from_ram <= from_ram_next;
    end
  end

  assign read_byte = from_ram ? rd_data : byte_q;

endmodule

### src/byte_ring_fifo_with_peek_cursor.sv
// Top level of the byte ring FIFO with a peek cursor.
//
// A byte FIFO of 64 entries that holds at most 63 bytes, with a third
// pointer, the peek cursor, that walks ahead of the read pointer. A request
// is taken at any rising edge where start is high and busy is low; busy never
// rises, so a new request can be taken every clock cycle. Each request gives
// exactly one result, shown on read_byte and status for one cycle with
// result_valid high, in the cycle after the request was taken; the receiver
// cannot stall it and must take it then. The byte store is a synchronous RAM
// with one write port and one registered read port; pointers are updated at
// the edge that takes the request, so the next request already sees them.
// Opcodes: push stores data_byte unless the FIFO is full; pop returns the
// oldest byte or reports empty; peek returns the byte at the cursor and
// advances it, first pushing data_byte when the cursor has reached the write
// pointer (status "no source data" if source_valid is low, "full" if there
// is no room); rewind moves the cursor back to the read pointer. A pop can
// move the read pointer past the cursor; the cursor is not corrected until
// a rewind. read_byte is zero for every result that carries no byte. The
// store has no reset and needs none.
module byte_ring_fifo_with_peek_cursor (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           opcode,
  input  bfp_pkg::byte_t       data_byte,
  input  logic                 source_valid,
  output logic                 result_valid,
  output bfp_pkg::byte_t       read_byte,
  output logic [1:0]           status
);

  import bfp_pkg::*;

  logic     accept;
  mem_req_t mem_req;
  byte_t    rd_data;
  status_t  status_int;

  // Every request completes its storage access without holding back the next
  // one, so the block is always ready.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  bfp_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .opcode       (op_t'(opcode)),
    .data_byte    (data_byte),
    .source_valid (source_valid),
    .mem_req      (mem_req),
    .rd_data      (rd_data),
    .result_valid (result_valid),
    .read_byte    (read_byte),
    .status       (status_int)
  );

  // The byte store: written at the tail pointer, read at head or cursor.
  bfp_ram #(
    .WIDTH (BYTE_W),
    .WORDS (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_req.wr_en),
    .wr_addr (mem_req.wr_addr),
    .wr_data (mem_req.wr_data),
    .rd_en   (mem_req.rd_en),
    .rd_addr (mem_req.rd_addr),
    .rd_data (rd_data)
  );

  assign status = 2'(status_int);

endmodule

### src/bfp_checker.sv
// Port-level assertions for the byte ring FIFO, bound to the top level.
module bfp_checker (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input logic [1:0]     opcode,
  input logic           result_valid,
  input bfp_pkg::byte_t read_byte,
  input logic [1:0]     status
);

  import bfp_pkg::*;

  // Every result answers a request taken in the previous cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(start && !busy))
    else $error("result without a request");

  // A failing result carries no byte.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && status != 2'(ST_OK)) |-> read_byte == '0)
    else $error("failing result carries a byte");

  // A push is answered in the next cycle with no byte and only ok or full.
  a_push_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && opcode == 2'(OP_PUSH)) |=>
      (result_valid && read_byte == '0 &&
       (status == 2'(ST_OK) || status == 2'(ST_FULL))))
    else $error("bad push result");

  // A pop is answered with ok or empty only.
  a_pop_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && opcode == 2'(OP_POP)) |=>
      (result_valid && (status == 2'(ST_OK) || status == 2'(ST_EMPTY))))
    else $error("bad pop status");

  // A rewind always succeeds with no byte.
  a_rewind_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && opcode == 2'(OP_REWIND)) |=>
      (result_valid && status == 2'(ST_OK) && read_byte == '0))
    else $error("bad rewind result");

endmodule

bind byte_ring_fifo_with_peek_cursor bfp_checker u_bfp_checker (.*);
